### hdl/iir_filter_transposed_df2_assert.svh
// Assertion macros used by the checker file of the IIR filter.
`ifndef IIR_FILTER_TRANSPOSED_DF2_ASSERT_SVH
`define IIR_FILTER_TRANSPOSED_DF2_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IFTD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iftd assertion failed");

// Next-cycle implication, disabled during reset.
`define IFTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iftd assertion failed");

`endif

### hdl/iftd_pkg.sv
// Shared types and constants of the IIR filter.
package iftd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int ZW       = 40;                // delay register width
  localparam int PW       = COEF_W + SAMPLE_W; // product width
  localparam int AW       = ZW + 1;            // output accumulator width
  localparam int UW       = ZW + 2;            // delay update sum width
  localparam int IDX_W    = 3;

  localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 18'sd16384;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_B3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_A1 = 3'd4;
  localparam logic [IDX_W-1:0] REG_A2 = 3'd5;
  localparam logic [IDX_W-1:0] REG_A3 = 3'd6;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture input sample, clear delays on start flag
    logic mul_x;    // b[k] * x
    logic round;    // y = round(b0*x + z0), saturate
    logic mul_y;    // a[k] * y
    logic update;   // delay update, load output register
  } iftd_cmd_t;

endpackage

### hdl/iir_filter_transposed_df2.sv
// Top level: third-order IIR filter, direct form II transposed.
// Steps of each item: b*x multiply, round of y, a*y multiply and delay update,
//   a dependent chain through the shared feedback path. The update loads the
//   output register, waits while it holds an untaken result, and can accept the next sample.
// Reset (rst, synchronous, active high): controller idle, output empty,
//   delays zero, b0 = 1.0 and all other coefficients zero.
module iir_filter_transposed_df2 import iftd_pkg::*; #(
  parameter int ORDER     = 3,   // 1 to 3
  parameter int FRAC_BITS = 14   // 8 to 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,    // [15:0] sample_in
  input  logic                 s_tuser,    // [0] start_of_block
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,    // [15:0] sample_out
  output logic                 m_tuser,    // [0] saturated
  // coefficient writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  iftd_cmd_t                  cmd;
  logic signed [SAMPLE_W-1:0] y_out;

  // Coefficient writes are always taken. The user must make them only while
  // the filter is idle (not enforced). Index 7 is dropped in the datapath decode.
  assign cfg_ready = 1'b1;

  // Controller: one item in flight, output register decouples the sides.
  iftd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Datapath: multiplier lanes, rounding/saturation, delay registers.
  iftd_datapath #(
    .ORDER     (ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sample_in      (s_tdata),
    .start_of_block (s_tuser),
    .cfg_wr         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_out     (y_out),
    .saturated      (m_tuser)
  );

  assign m_tdata = y_out;

endmodule

### hdl/iftd_ctrl.sv
// Sequencer of the IIR filter: handshakes and step commands.
module iftd_ctrl import iftd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output iftd_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MULX  = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_MULY  = 5'b01000,
    ST_UPD   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_free, upd_go, accept;

  assign out_free = !m_tvalid || m_tready;
  assign upd_go   = (state == ST_UPD) && out_free;
  assign s_tready = (state == ST_IDLE) || upd_go;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_MULX;
      ST_MULX:  state_next = ST_ROUND;
      ST_ROUND: state_next = ST_MULY;
      ST_MULY:  state_next = ST_UPD;
      ST_UPD: begin
        if (upd_go) state_next = accept ? ST_MULX : ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (upd_go)        m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    cmd.load   = accept;
    cmd.mul_x  = (state == ST_MULX);
    cmd.round  = (state == ST_ROUND);
    cmd.mul_y  = (state == ST_MULY);
    cmd.update = upd_go;
  end

endmodule

### hdl/iftd_datapath.sv
// Datapath of the IIR filter: coefficients, multiplier lanes, delays, output.
module iftd_datapath import iftd_pkg::*; #(
  parameter int ORDER     = 3,
  parameter int FRAC_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  iftd_cmd_t                  cmd,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       start_of_block,
  input  logic                       cfg_wr,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic signed [COEF_W-1:0]   cfg_data,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       saturated
);

  localparam logic signed [AW-1:0] RND = AW'(64'd1 << (FRAC_BITS - 1));

  logic signed [COEF_W-1:0]   coef_b [0:3];
  logic signed [COEF_W-1:0]   coef_a [1:3];
  logic signed [SAMPLE_W-1:0] x;
  logic signed [PW-1:0]       pb [0:ORDER];
  logic signed [PW-1:0]       pa [0:ORDER-1];
  logic signed [ZW-1:0]       z  [0:ORDER-1];
  logic signed [ZW-1:0]       z_next [0:ORDER-1];
  logic signed [UW-1:0]       usum [0:ORDER-1];
  logic signed [SAMPLE_W-1:0] y, y_next;
  logic                       sat, ovf;
  logic signed [AW-1:0]       acc, yw;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b[0] <= COEF_B0_RESET;
      coef_b[1] <= '0;
      coef_b[2] <= '0;
      coef_b[3] <= '0;
      coef_a[1] <= '0;
      coef_a[2] <= '0;
      coef_a[3] <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_B0:  coef_b[0] <= cfg_data;
        REG_B1:  coef_b[1] <= cfg_data;
        REG_B2:  coef_b[2] <= cfg_data;
        REG_B3:  coef_b[3] <= cfg_data;
        REG_A1:  coef_a[1] <= cfg_data;
        REG_A2:  coef_a[2] <= cfg_data;
        REG_A3:  coef_a[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) x <= sample_in;
  end

  // multiplier lanes, one per coefficient
  always_ff @(posedge clk) begin
    if (cmd.mul_x) begin
      for (int k = 0; k <= ORDER; k++) pb[k] <= PW'(coef_b[k]) * PW'(x);
    end
    if (cmd.mul_y) begin
      for (int k = 0; k < ORDER; k++) pa[k] <= PW'(coef_a[k+1]) * PW'(y);
    end
  end

  // output: round half up, then clip to 16 bits
  assign acc = AW'(pb[0]) + AW'(z[0]) + RND;
  assign yw  = acc >>> FRAC_BITS;
  assign ovf = !((&yw[AW-1:SAMPLE_W-1]) || !(|yw[AW-1:SAMPLE_W-1]));
  assign y_next = ovf ? (yw[AW-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_W-1){1'b1}}})
                      : yw[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      y   <= y_next;
      sat <= ovf;
    end
  end

  // delay update with clamp to the delay width
  for (genvar j = 0; j < ORDER; j++) begin : g_upd
    if (j + 1 < ORDER) begin : g_mid
      assign usum[j] = UW'(pb[j+1]) - UW'(pa[j]) + UW'(z[j+1]);
    end else begin : g_last
      assign usum[j] = UW'(pb[j+1]) - UW'(pa[j]);
    end
    assign z_next[j] = ((&usum[j][UW-1:ZW-1]) || !(|usum[j][UW-1:ZW-1]))
                       ? usum[j][ZW-1:0]
                       : (usum[j][UW-1] ? {1'b1, {(ZW-1){1'b0}}}
                                        : {1'b0, {(ZW-1){1'b1}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < ORDER; j++) z[j] <= '0;
    end else begin
      if (cmd.update) begin
        for (int j = 0; j < ORDER; j++) z[j] <= z_next[j];
      end
      // start of a new trace wins over an update in the same cycle
      if (cmd.load && start_of_block) begin
        for (int j = 0; j < ORDER; j++) z[j] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      sample_out <= y;
      saturated  <= sat;
    end
  end

endmodule

### hdl/iftd_checker.sv
// Port-level checker of the IIR filter, bound to the top level.
`include "iir_filter_transposed_df2_assert.svh"

module iftd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // stalled result holds
  `IFTD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // a clipped result sits at one of the two rails
  `IFTD_ASSERT_IMPL(a_sat_rail, m_tvalid && m_tuser, m_tdata == 16'h7fff || m_tdata == 16'h8000)
  // after an input transfer the filter is busy through the b*x multiply, round and a*y steps
  `IFTD_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready ##1 !s_tready ##1 !s_tready)

endmodule

bind iir_filter_transposed_df2 iftd_checker u_iftd_checker (.*);

### dv/tb_iir_filter_transposed_df2.sv
// Testbench for iir_filter_transposed_df2: sample streams checked against a predictor.
module tb_iir_filter_transposed_df2 import iftd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ORDER       = 3;
  localparam int FRAC_BITS   = 14;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 76;

  // unmapped register index; the block must drop writes to it
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  localparam logic [IDX_W-1:0] REG_MAP [7] = '{REG_B0, REG_B1, REG_B2, REG_B3,
                                               REG_A1, REG_A2, REG_A3};

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // how a coefficient set is chosen for a phase
  typedef enum int {PLAN_FULL, PLAN_MILD, PLAN_MAX, PLAN_MIN} coef_plan_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                sat;
  } filt_out_t;

  // Predicts the filter output for every accepted sample and checks the
  // output transfers against it in order.
  class iir_scoreboard;
    longint    b_coef [4];
    longint    a_coef [4];     // a_coef[0] unused (a0 = 1)
    longint    delay [ORDER];  // delays, FRAC_BITS fractional bits
    filt_out_t expected_out [$];
    int        errors;

    function new();
      foreach (b_coef[k]) b_coef[k] = 0;
      foreach (a_coef[k]) a_coef[k] = 0;
      foreach (delay[k]) delay[k] = 0;
      b_coef[0] = COEF_B0_RESET;
      errors = 0;
    endfunction

    function void set_coef(logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
      case (idx)
        REG_B0: b_coef[0] = val;
        REG_B1: b_coef[1] = val;
        REG_B2: b_coef[2] = val;
        REG_B3: b_coef[3] = val;
        REG_A1: a_coef[1] = val;
        REG_A2: a_coef[2] = val;
        REG_A3: a_coef[3] = val;
        default: ;
      endcase
    endfunction

    // One step of the transposed direct form II recursion.
    function filt_out_t filter_sample(logic [SAMPLE_W-1:0] data, logic sob);
      filt_out_t res;
      longint    x, acc, y, upd;
      longint    zmax, zmin;
      zmax = (longint'(1) <<< (ZW - 1)) - 1;
      zmin = -zmax - 1;
      x = longint'($signed(data));
      if (sob) begin
        foreach (delay[k]) delay[k] = 0;
      end
      acc = b_coef[0] * x + delay[0];
      // round half up, arithmetic shift gives the floor
      y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      res.sat = 1'b0;
      if (y > 32767) begin
        y = 32767;
        res.sat = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        res.sat = 1'b1;
      end
      // clipped y is what feeds back; ascending order reads the old next delay
      for (int j = 0; j < ORDER; j++) begin
        upd = b_coef[j+1] * x - a_coef[j+1] * y;
        if (j + 1 < ORDER) upd += delay[j+1];
        if (upd > zmax) upd = zmax;
        if (upd < zmin) upd = zmin;
        delay[j] = upd;
      end
      res.sample = y[SAMPLE_W-1:0];
      return res;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] data, logic sob);
      expected_out.push_back(filter_sample(data, sob));
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] data, logic sat);
      filt_out_t want;
      if (expected_out.size() == 0) begin
        $display("%0t: output transfer with none pending: sample_out %0d saturated %0b",
                 $time, $signed(data), sat);
        errors++;
        return;
      end
      want = expected_out.pop_front();
      if (data !== want.sample) begin
        $display("%0t: sample_out expected %0d, got %0d",
                 $time, $signed(want.sample), $signed(data));
        errors++;
      end
      if (sat !== want.sat) begin
        $display("%0t: saturated expected %0b, got %0b", $time, want.sat, sat);
        errors++;
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [15:0]          s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [15:0]          m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  iir_scoreboard sb = new();

  logic signed [COEF_W-1:0] coef_plan [7];
  bit                       no_gaps;     // phase runs with both sides at full rate
  int                       cycle_cnt;
  int                       rdy_hold;

  iir_filter_transposed_df2 #(
    .ORDER    (ORDER),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sample mix: extremes, full-range noise, and small values that keep
  // the recursion out of saturation.
  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  function automatic void fill_coef_plan(coef_plan_t mode);
    foreach (coef_plan[k]) begin
      case (mode)
        PLAN_MAX:  coef_plan[k] = COEF_MAX;
        PLAN_MIN:  coef_plan[k] = COEF_MIN;
        PLAN_MILD: coef_plan[k] = COEF_W'(int'($urandom_range(0, 24000)) - 12000);
        default:   coef_plan[k] = COEF_W'($urandom);
      endcase
    end
  endfunction

  // Output side backpressure: tready held for random stretches.
  always @(negedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold = rdy_hold - 1;
    end else if (no_gaps) begin
      m_tready <= 1'b1;
    end else if ($urandom_range(0, 2) != 0) begin
      m_tready <= 1'b1;
      rdy_hold = $urandom_range(0, 6);
    end else begin
      m_tready <= 1'b0;
      rdy_hold = pick_gap();
    end
  end

  // Every output transfer goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // One input transfer, preceded by a random idle stretch. tvalid stays high
  // after the transfer so back-to-back items need no extra step.
  task automatic send_sample(input logic [15:0] data, input logic sob);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 16'($urandom);
      s_tuser  <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= sob;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(data, sob);
  endtask

  // Stop sending and hold off until every pending result has come out.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the planned set, then a dropped write to the unmapped index.
  task automatic load_coefs();
    logic [COEF_W-1:0] junk;
    for (int k = 0; k < 8; k++) begin
      junk = COEF_W'($urandom);
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= (k < 7) ? REG_MAP[k] : REG_NONE;
      cfg_data  <= (k < 7) ? coef_plan[k] : junk;
      do @(posedge clk); while (!cfg_ready);
      if (k < 7) sb.set_coef(REG_MAP[k], coef_plan[k]);
      else sb.set_coef(REG_NONE, junk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Watchdog.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    coef_plan_t mode;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_gaps   = 1'b0;
    cycle_cnt = 0;
    rdy_hold  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset coefficients: b0 = 1.0, so the output follows the input.
    send_sample(16'h0000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    drain();

    // Coefficient extremes: clipping both ways, clipped y fed back,
    // start flag clearing a loaded delay line.
    coef_plan = '{COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN};
    load_coefs();
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'd12345, 1'b0);
    send_sample(16'h0000, 1'b1);
    drain();

    // b0 = 0.5 alone: exact halves round up (0.5 -> 1, -0.5 -> 0,
    // 1.5 -> 2, -1.5 -> -1).
    coef_plan = '{18'sd8192, '0, '0, '0, '0, '0, '0};
    load_coefs();
    send_sample(16'h0001, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0003, 1'b0);
    send_sample(16'hFFFD, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    drain();

    // Random phases: all-min, all-max, then random sets. Each ends with a
    // full drain before the next coefficient load.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: mode = PLAN_MIN;
        1: mode = PLAN_MAX;
        3: mode = PLAN_FULL;
        default: mode = PLAN_MILD;
      endcase
      fill_coef_plan(mode);
      load_coefs();
      no_gaps = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(pick_sample(), ($urandom_range(0, 11) == 0) || (i == 0));
      end
      drain();
      no_gaps = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/iftd_pkg.sv
hdl/iftd_ctrl.sv
hdl/iftd_datapath.sv
hdl/iir_filter_transposed_df2.sv
hdl/iftd_checker.sv
dv/tb_iir_filter_transposed_df2.sv
